>>> sv/assert_macros.svh
// assertion macros shared by the recorder rtl
// clock and reset are taken from the scope of the module that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/rfps_pkg.sv
`timescale 1ns / 1ps
// shared constants and types of the recorder fade and peak summary block
// no dependencies
package rfps_pkg;

   localparam int ADDR_BITS_DEF   = 20;
   localparam int SAMPLE_BITS_DEF = 16;
   localparam int CMD_DEPTH       = 4;
   localparam int RSP_DEPTH       = 4;

   localparam int POS_W     = 21;
   localparam int GAIN_W    = 17;
   localparam int CSR_W     = 21;
   localparam int CSR_IDX_W = 2;

   localparam logic [GAIN_W-1:0] GAIN_ONE = 17'h10000;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_RECORD_FRAMES = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_RAMP_FRAMES   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_RAMP_STEP     = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_CHUNK_SAMPLES = 2'd3;

   // register reset values
   localparam logic [POS_W-1:0]  RECORD_FRAMES_RST = 21'd44100;
   localparam logic [POS_W-1:0]  RAMP_FRAMES_RST   = 21'd882;
   localparam logic [GAIN_W-1:0] RAMP_STEP_RST     = 17'd74;
   localparam logic [POS_W-1:0]  CHUNK_SAMPLES_RST = 21'd441;
   localparam logic [POS_W-1:0]  DECAY_START_RST   = 21'd43218;

   // result kinds
   localparam logic [1:0] KIND_WRITE = 2'd0;
   localparam logic [1:0] KIND_START = 2'd1;
   localparam logic [1:0] KIND_CHUNK = 2'd2;
   localparam logic [1:0] KIND_DROP  = 2'd3;

   // classification of one item, front to back
   typedef struct packed {
      logic start;
      logic drop;
      logic chunk;
   } cmd_flags_type;

   localparam int FLAGS_W = $bits(cmd_flags_type);

endpackage

>>> sv/rfps_queue.sv
`timescale 1ns / 1ps
// small register queue used between front, back and the result port
// depends on assert_macros.svh
`include "assert_macros.svh"
module rfps_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wdata;
      end
   end

   `ASSERT_ALWAYS(a_count_bound, count_ff <= CNT_W'(DEPTH), "queue count past depth")
   `ASSERT_NEXT(a_pop_only_drain, do_pop && !do_push, count_ff == $past(count_ff) - 1'b1, "pop did not drain")

endmodule

>>> sv/rfps_front.sv
`timescale 1ns / 1ps
// front: settings registers, write position, fade gain and chunk counters
// classifies each item for the back; depends on rfps_pkg and assert_macros.svh
`include "assert_macros.svh"
module rfps_front #(
   parameter int ADDR_BITS   = rfps_pkg::ADDR_BITS_DEF,
   parameter int SAMPLE_BITS = rfps_pkg::SAMPLE_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wen,
   input  logic [rfps_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [rfps_pkg::CSR_W-1:0]        csr_wdata,
   input  logic                              accept,
   input  logic signed [SAMPLE_BITS-1:0]     sample_in,
   input  logic                              restart,
   output rfps_pkg::cmd_flags_type           cmd_flags,
   output logic [ADDR_BITS-1:0]              cmd_addr,
   output logic signed [SAMPLE_BITS-1:0]     cmd_sample,
   output logic [rfps_pkg::GAIN_W-1:0]       cmd_gain,
   output logic [ADDR_BITS-1:0]              cmd_chunk_num
);

   import rfps_pkg::*;

   logic [POS_W-1:0]  rec_ff, rec_in;
   logic [POS_W-1:0]  ramp_ff, ramp_in;
   logic [GAIN_W-1:0] step_ff, step_in;
   logic [POS_W-1:0]  limit_ff, limit_in;
   logic [POS_W-1:0]  decay_ff, decay_in;

   logic [POS_W-1:0]     pos_ff, pos_in;
   logic [GAIN_W-1:0]    gain_ff, gain_in;
   logic [POS_W-1:0]     count_ff, count_in;
   logic [ADDR_BITS-1:0] chunk_ff, chunk_in;

   logic [POS_W-1:0]     pos_eff, count_eff;
   logic [GAIN_W-1:0]    gain_eff, gain_sat, gain_dn;
   logic [ADDR_BITS-1:0] chunk_eff;
   logic [GAIN_W:0]      gain_up;
   logic [POS_W:0]       pos_inc;
   logic                 is_start, is_drop, in_ramp, in_decay, is_chunk;
   logic [POS_W+ADDR_BITS-1:0] addr_wide;

   // settings writes; decay start follows the new values in the same edge
   always_comb begin
      rec_in   = rec_ff;
      ramp_in  = ramp_ff;
      step_in  = step_ff;
      limit_in = limit_ff;
      if (csr_wen) begin
         case (csr_index)
            REG_RECORD_FRAMES: rec_in   = csr_wdata;
            REG_RAMP_FRAMES:   ramp_in  = csr_wdata;
            REG_RAMP_STEP:     step_in  = csr_wdata[GAIN_W-1:0];
            REG_CHUNK_SAMPLES: limit_in = csr_wdata;
            default: ;
         endcase
      end
      decay_in = (ramp_in > rec_in) ? '0 : rec_in - ramp_in;
   end

   always_comb begin
      pos_eff   = restart ? '0 : pos_ff;
      is_start  = (pos_eff == '0);
      gain_eff  = is_start ? '0 : gain_ff;
      count_eff = is_start ? '0 : count_ff;
      chunk_eff = is_start ? '0 : chunk_ff;

      is_drop  = (pos_eff >= rec_ff);
      in_ramp  = (pos_eff < ramp_ff);
      in_decay = (pos_eff >= decay_ff);

      gain_up  = {1'b0, gain_eff} + {1'b0, step_ff};
      gain_sat = (gain_up > {1'b0, GAIN_ONE}) ? GAIN_ONE : gain_up[GAIN_W-1:0];
      gain_dn  = (gain_eff < step_ff) ? '0 : gain_eff - step_ff;

      pos_inc  = {1'b0, pos_eff} + 1'b1;
      is_chunk = (count_eff >= limit_ff) || (pos_inc >= {1'b0, rec_ff});

      if (is_drop) begin
         pos_in   = pos_eff;
         gain_in  = gain_eff;
         count_in = count_eff;
         chunk_in = chunk_eff;
      end else begin
         pos_in = pos_inc[POS_W-1:0];
         if (in_ramp) begin
            gain_in = gain_sat;
         end else if (in_decay) begin
            gain_in = gain_dn;
         end else begin
            gain_in = gain_eff;
         end
         count_in = is_chunk ? '0 : count_eff + 1'b1;
         chunk_in = is_chunk ? chunk_eff + 1'b1 : chunk_eff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rec_ff   <= RECORD_FRAMES_RST;
         ramp_ff  <= RAMP_FRAMES_RST;
         step_ff  <= RAMP_STEP_RST;
         limit_ff <= CHUNK_SAMPLES_RST;
         decay_ff <= DECAY_START_RST;
         pos_ff   <= '0;
         gain_ff  <= '0;
         count_ff <= '0;
         chunk_ff <= '0;
      end else begin
         rec_ff   <= rec_in;
         ramp_ff  <= ramp_in;
         step_ff  <= step_in;
         limit_ff <= limit_in;
         decay_ff <= decay_in;
         if (accept) begin
            pos_ff   <= pos_in;
            gain_ff  <= gain_in;
            count_ff <= count_in;
            chunk_ff <= chunk_in;
         end
      end
   end

   // position zero-extends or truncates to the address width
   assign addr_wide = {{ADDR_BITS{1'b0}}, pos_eff};

   assign cmd_flags.start = is_start;
   assign cmd_flags.drop  = is_drop;
   assign cmd_flags.chunk = is_chunk && !is_drop;
   assign cmd_addr        = addr_wide[ADDR_BITS-1:0];
   assign cmd_sample      = sample_in;
   // unity gain between the ramps
   assign cmd_gain        = (in_ramp || in_decay) ? gain_eff : GAIN_ONE;
   assign cmd_chunk_num   = chunk_eff;

   `ASSERT_ALWAYS(a_gain_max, gain_ff <= GAIN_ONE, "fade gain above unity")
   `ASSERT_NEXT(a_drop_holds_pos, accept && is_drop, pos_ff == $past(pos_eff), "drop moved position")

endmodule

>>> sv/rfps_back.sv
`timescale 1ns / 1ps
// back: fade multiply, running min and max, and result sequencing, one result
// per cycle while out_full is low; depends on rfps_pkg and assert_macros.svh
`include "assert_macros.svh"
module rfps_back #(
   parameter int ADDR_BITS   = rfps_pkg::ADDR_BITS_DEF,
   parameter int SAMPLE_BITS = rfps_pkg::SAMPLE_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              cmd_valid,
   output logic                              cmd_pop,
   input  rfps_pkg::cmd_flags_type           cmd_flags,
   input  logic [ADDR_BITS-1:0]              cmd_addr,
   input  logic signed [SAMPLE_BITS-1:0]     cmd_sample,
   input  logic [rfps_pkg::GAIN_W-1:0]       cmd_gain,
   input  logic [ADDR_BITS-1:0]              cmd_chunk_num,
   input  logic                              out_full,
   output logic                              out_push,
   output logic [1:0]                        out_kind,
   output logic [ADDR_BITS-1:0]              out_addr,
   output logic signed [SAMPLE_BITS-1:0]     out_sample,
   output logic [ADDR_BITS-1:0]              out_chunk_num,
   output logic signed [SAMPLE_BITS-1:0]     out_low,
   output logic signed [SAMPLE_BITS-1:0]     out_high,
   output logic                              out_last
);

   import rfps_pkg::*;

   localparam int PW = SAMPLE_BITS + GAIN_W + 1;
   localparam logic signed [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
   localparam logic signed [PW-1:0] SMAX_W = PW'(SMAX);
   localparam logic signed [PW-1:0] SMIN_W = PW'(SMIN);
   localparam logic signed [PW-1:0] HALF   = PW'(32768);

   typedef enum logic [2:0] {
      PH_START = 3'b001,
      PH_MAIN  = 3'b010,
      PH_CHUNK = 3'b100
   } phase_type;

   logic                  valid_ff, valid_in;
   phase_type             phase_ff, phase_in;
   cmd_flags_type         flags_ff;
   logic [ADDR_BITS-1:0]  addr_ff, num_ff;
   logic signed [PW-1:0]  prod_ff, prod_in;
   logic signed [SAMPLE_BITS-1:0] low_ff, low_in, high_ff, high_in;

   logic signed [GAIN_W:0] gain_s;
   logic signed [PW-1:0]   rnd, shifted;
   logic signed [SAMPLE_BITS-1:0] y;
   logic emit, last, done, load;

   assign gain_s  = {1'b0, cmd_gain};
   assign prod_in = cmd_sample * gain_s;

   // round half up, then clamp to the sample range
   always_comb begin
      rnd     = prod_ff + HALF;
      shifted = rnd >>> 16;
      if (shifted > SMAX_W) begin
         y = SMAX;
      end else if (shifted < SMIN_W) begin
         y = SMIN;
      end else begin
         y = shifted[SAMPLE_BITS-1:0];
      end
   end

   always_comb begin
      last = 1'b0;
      case (phase_ff)
         PH_START: last = 1'b0;
         PH_MAIN:  last = flags_ff.drop || !flags_ff.chunk;
         PH_CHUNK: last = 1'b1;
         default:  last = 1'b1;
      endcase
   end

   assign emit     = valid_ff && !out_full;
   assign done     = emit && last;
   assign load     = cmd_valid && (!valid_ff || done);
   assign cmd_pop  = load;
   assign out_push = emit;

   always_comb begin
      valid_in = valid_ff;
      phase_in = phase_ff;
      if (load) begin
         valid_in = 1'b1;
         phase_in = cmd_flags.start ? PH_START : PH_MAIN;
      end else if (done) begin
         valid_in = 1'b0;
      end else if (emit) begin
         case (phase_ff)
            PH_START: phase_in = PH_MAIN;
            PH_MAIN:  phase_in = PH_CHUNK;
            default:  phase_in = phase_ff;
         endcase
      end
   end

   // start and chunk clear the running extremes, a write folds in y
   always_comb begin
      low_in  = low_ff;
      high_in = high_ff;
      if (emit) begin
         case (phase_ff)
            PH_START, PH_CHUNK: begin
               low_in  = SMAX;
               high_in = SMIN;
            end
            PH_MAIN: begin
               if (!flags_ff.drop) begin
                  if (y < low_ff) low_in = y;
                  if (y > high_ff) high_in = y;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         phase_ff <= PH_MAIN;
         low_ff   <= SMAX;
         high_ff  <= SMIN;
      end else begin
         valid_ff <= valid_in;
         phase_ff <= phase_in;
         low_ff   <= low_in;
         high_ff  <= high_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         flags_ff <= cmd_flags;
         addr_ff  <= cmd_addr;
         num_ff   <= cmd_chunk_num;
         prod_ff  <= prod_in;
      end
   end

   always_comb begin
      out_kind      = KIND_START;
      out_addr      = '0;
      out_sample    = '0;
      out_chunk_num = '0;
      out_low       = '0;
      out_high      = '0;
      case (phase_ff)
         PH_START: out_kind = KIND_START;
         PH_MAIN: begin
            if (flags_ff.drop) begin
               out_kind = KIND_DROP;
            end else begin
               out_kind   = KIND_WRITE;
               out_addr   = addr_ff;
               out_sample = y;
            end
         end
         PH_CHUNK: begin
            out_kind      = KIND_CHUNK;
            out_chunk_num = num_ff;
            out_low       = low_ff;
            out_high      = high_ff;
         end
         default: out_kind = KIND_START;
      endcase
   end

   assign out_last = last;

   `ASSERT_ALWAYS(a_chunk_flagged, !(valid_ff && phase_ff == PH_CHUNK) || flags_ff.chunk, "chunk phase without chunk flag")
   `ASSERT_NEXT(a_chunk_clears, emit && phase_ff == PH_CHUNK, low_ff == SMAX && high_ff == SMIN, "extremes not cleared after chunk")

endmodule

>>> sv/recorder_fade_and_peak_summary.sv
`timescale 1ns / 1ps
// recorder with fade envelope and min/max chunk summaries, top level
// path: accepted item -> command queue -> back registers -> result queue -> rsp ports
// the back writes its 1 to 3 results one a cycle while the result queue has room; the
// front takes an item every cycle that the command queue is not full
// reset: synchronous active high; settings return to defaults, position and queues clear
module recorder_fade_and_peak_summary #(
   parameter int ADDR_BITS   = rfps_pkg::ADDR_BITS_DEF,
   parameter int SAMPLE_BITS = rfps_pkg::SAMPLE_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wen,
   input  logic [rfps_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [rfps_pkg::CSR_W-1:0]        csr_wdata,
   input  logic                              push,
   output logic                              full,
   input  logic signed [SAMPLE_BITS-1:0]     req_sample_in,
   input  logic                              req_restart,
   output logic                              empty,
   input  logic                              pop,
   output logic [1:0]                        rsp_result_kind,
   output logic [ADDR_BITS-1:0]              rsp_write_addr,
   output logic signed [SAMPLE_BITS-1:0]     rsp_sample_out,
   output logic [ADDR_BITS-1:0]              rsp_chunk_number,
   output logic signed [SAMPLE_BITS-1:0]     rsp_chunk_low,
   output logic signed [SAMPLE_BITS-1:0]     rsp_chunk_high,
   output logic                              rsp_last_of_run
);

   import rfps_pkg::*;

   localparam int CMD_W = FLAGS_W + 2 * ADDR_BITS + SAMPLE_BITS + GAIN_W;
   localparam int RSP_W = 3 + 2 * ADDR_BITS + 3 * SAMPLE_BITS;

   logic accept;

   cmd_flags_type                 f_flags, q_flags;
   logic [ADDR_BITS-1:0]          f_addr, q_addr, f_num, q_num;
   logic signed [SAMPLE_BITS-1:0] f_sample, q_sample;
   logic [GAIN_W-1:0]             f_gain, q_gain;
   logic [CMD_W-1:0]              cmd_wdata, cmd_rdata;
   logic                          cmd_empty, cmd_pop;

   logic                          out_full, out_push, out_last;
   logic [1:0]                    out_kind;
   logic [ADDR_BITS-1:0]          out_addr, out_num;
   logic signed [SAMPLE_BITS-1:0] out_sample, out_low, out_high;
   logic [RSP_W-1:0]              rsp_wdata, rsp_rdata;

   assign accept = push && !full;

   rfps_front #(
      .ADDR_BITS   (ADDR_BITS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .csr_wen       (csr_wen),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .accept        (accept),
      .sample_in     (req_sample_in),
      .restart       (req_restart),
      .cmd_flags     (f_flags),
      .cmd_addr      (f_addr),
      .cmd_sample    (f_sample),
      .cmd_gain      (f_gain),
      .cmd_chunk_num (f_num)
   );

   assign cmd_wdata = {f_flags, f_addr, f_sample, f_gain, f_num};

   rfps_queue #(
      .WIDTH (CMD_W),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .wdata (cmd_wdata),
      .full  (full),
      .pop   (cmd_pop),
      .rdata (cmd_rdata),
      .empty (cmd_empty)
   );

   assign {q_flags, q_addr, q_sample, q_gain, q_num} = cmd_rdata;

   rfps_back #(
      .ADDR_BITS   (ADDR_BITS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .cmd_valid     (!cmd_empty),
      .cmd_pop       (cmd_pop),
      .cmd_flags     (q_flags),
      .cmd_addr      (q_addr),
      .cmd_sample    (q_sample),
      .cmd_gain      (q_gain),
      .cmd_chunk_num (q_num),
      .out_full      (out_full),
      .out_push      (out_push),
      .out_kind      (out_kind),
      .out_addr      (out_addr),
      .out_sample    (out_sample),
      .out_chunk_num (out_num),
      .out_low       (out_low),
      .out_high      (out_high),
      .out_last      (out_last)
   );

   assign rsp_wdata = {out_kind, out_addr, out_sample, out_num, out_low, out_high, out_last};

   rfps_queue #(
      .WIDTH (RSP_W),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (out_push),
      .wdata (rsp_wdata),
      .full  (out_full),
      .pop   (pop),
      .rdata (rsp_rdata),
      .empty (empty)
   );

   assign {rsp_result_kind, rsp_write_addr, rsp_sample_out, rsp_chunk_number,
           rsp_chunk_low, rsp_chunk_high, rsp_last_of_run} = rsp_rdata;

endmodule

>>> tb/tb_recorder_fade_and_peak_summary.sv
`timescale 1ns / 1ps
// self-checking testbench for recorder_fade_and_peak_summary
// depends on rfps_pkg and the recorder rtl; a small scoreboard class predicts every result
module tb_recorder_fade_and_peak_summary;
   import rfps_pkg::*;

   localparam int LIMIT = 400000;
   localparam logic signed [15:0] S_MAX = 16'sh7fff;
   localparam logic signed [15:0] S_MIN = 16'sh8000;

   typedef struct packed {
      logic [1:0]         kind;
      logic [19:0]        addr;
      logic signed [15:0] sample;
      logic [19:0]        number;
      logic signed [15:0] chunk_lo;
      logic signed [15:0] chunk_hi;
      logic               last;
   } recorder_result_type;

   class fade_summary_board;
      logic [POS_W-1:0]   record_frames, ramp_frames, chunk_samples;
      logic [GAIN_W-1:0]  ramp_step;
      logic [POS_W-1:0]   pos, run_count;
      logic [GAIN_W-1:0]  gain;
      logic [19:0]        next_chunk;
      logic signed [15:0] run_low, run_high;
      recorder_result_type expected_results[$];
      int errors, items, writes, chunks, drops;

      function new();
         record_frames = RECORD_FRAMES_RST;
         ramp_frames = RAMP_FRAMES_RST;
         ramp_step = RAMP_STEP_RST;
         chunk_samples = CHUNK_SAMPLES_RST;
         pos = '0;
         gain = '0;
         next_chunk = '0;
         clear_chunk();
         errors = 0;
         items = 0;
         writes = 0;
         chunks = 0;
         drops = 0;
      endfunction

      function void clear_chunk();
         run_low = S_MAX;
         run_high = S_MIN;
         run_count = '0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] value);
         case (idx)
            REG_RECORD_FRAMES: record_frames = value;
            REG_RAMP_FRAMES:   ramp_frames = value;
            REG_RAMP_STEP:     ramp_step = value[GAIN_W-1:0];
            REG_CHUNK_SAMPLES: chunk_samples = value;
            default: ;
         endcase
      endfunction

      function int pending();
         return expected_results.size();
      endfunction

      function void add(logic [1:0] kind, logic [19:0] addr, logic signed [15:0] smp,
                        logic [19:0] num, logic signed [15:0] lo, logic signed [15:0] hi,
                        logic last);
         recorder_result_type r;
         r.kind = kind;
         r.addr = addr;
         r.sample = smp;
         r.number = num;
         r.chunk_lo = lo;
         r.chunk_hi = hi;
         r.last = last;
         expected_results.push_back(r);
      endfunction

      // q1.16 gain, round half up, clamped to the sample range
      function logic signed [15:0] fade_gain(logic signed [15:0] s, logic [GAIN_W-1:0] g);
         longint acc;
         acc = (longint'(s) * longint'(g) + 32768) >>> 16;
         if (acc > 32767) acc = 32767;
         if (acc < -32768) acc = -32768;
         return acc[15:0];
      endfunction

      function void note_sample(logic signed [15:0] s, logic restart);
         logic [POS_W-1:0]   decay;
         logic signed [15:0] y;
         logic [GAIN_W:0]    raised;
         logic               due;
         items++;
         if (restart) pos = '0;
         if (pos == 0) begin
            add(KIND_START, '0, '0, '0, '0, '0, 1'b0);
            clear_chunk();
            next_chunk = '0;
            gain = '0;
         end
         if (pos >= record_frames) begin
            add(KIND_DROP, '0, '0, '0, '0, '0, 1'b1);
            drops++;
            return;
         end
         // decay start saturates at zero when the ramp is longer than the recording
         decay = (ramp_frames > record_frames) ? '0 : record_frames - ramp_frames;
         if (pos < ramp_frames) begin
            y = fade_gain(s, gain);
            raised = gain + ramp_step;
            gain = (raised > GAIN_ONE) ? GAIN_ONE : raised[GAIN_W-1:0];
         end else if (pos >= decay) begin
            y = fade_gain(s, gain);
            gain = (gain < ramp_step) ? '0 : gain - ramp_step;
         end else begin
            y = s;
         end
         due = (run_count >= chunk_samples) || (pos + 1'b1 >= record_frames);
         add(KIND_WRITE, pos[19:0], y, '0, '0, '0, !due);
         writes++;
         if (y < run_low) run_low = y;
         if (y > run_high) run_high = y;
         if (due) begin
            add(KIND_CHUNK, '0, '0, next_chunk, run_low, run_high, 1'b1);
            chunks++;
            next_chunk = next_chunk + 1'b1;
            clear_chunk();
         end else begin
            run_count = run_count + 1'b1;
         end
         pos = pos + 1'b1;
      endfunction

      function void compare(string field, longint want, longint got);
         if (want != got) begin
            $error("%s: expected %0d, actual %0d", field, want, got);
            errors++;
         end
      endfunction

      function void check_result(recorder_result_type got);
         recorder_result_type want;
         if (expected_results.size() == 0) begin
            $error("result_kind: expected none, actual %0d", got.kind);
            errors++;
            return;
         end
         want = expected_results.pop_front();
         compare("result_kind", want.kind, got.kind);
         compare("write_addr", want.addr, got.addr);
         compare("sample_out", want.sample, got.sample);
         compare("chunk_number", want.number, got.number);
         compare("chunk_low", want.chunk_lo, got.chunk_lo);
         compare("chunk_high", want.chunk_hi, got.chunk_hi);
         compare("last_of_run", want.last, got.last);
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_wen = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]     csr_wdata = '0;
   logic                 push = 1'b0;
   logic                 full;
   logic signed [15:0]   req_sample_in = '0;
   logic                 req_restart = 1'b0;
   logic                 empty;
   logic                 pop = 1'b0;
   logic [1:0]           rsp_result_kind;
   logic [19:0]          rsp_write_addr;
   logic signed [15:0]   rsp_sample_out;
   logic [19:0]          rsp_chunk_number;
   logic signed [15:0]   rsp_chunk_low;
   logic signed [15:0]   rsp_chunk_high;
   logic                 rsp_last_of_run;

   bit steady = 1'b0;
   int cycles = 0;
   fade_summary_board board;

   recorder_fade_and_peak_summary uut (
      .clock            (clock),
      .reset            (reset),
      .csr_wen          (csr_wen),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .push             (push),
      .full             (full),
      .req_sample_in    (req_sample_in),
      .req_restart      (req_restart),
      .empty            (empty),
      .pop              (pop),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_write_addr   (rsp_write_addr),
      .rsp_sample_out   (rsp_sample_out),
      .rsp_chunk_number (rsp_chunk_number),
      .rsp_chunk_low    (rsp_chunk_low),
      .rsp_chunk_high   (rsp_chunk_high),
      .rsp_last_of_run  (rsp_last_of_run)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles >= LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && push && !full) begin
         board.note_sample(req_sample_in, req_restart);
      end
   end

   // result side: random pop stalls except in the steady stretch
   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            board.check_result('{rsp_result_kind, rsp_write_addr, rsp_sample_out,
                                 rsp_chunk_number, rsp_chunk_low, rsp_chunk_high,
                                 rsp_last_of_run});
         end
         pop <= steady || ($urandom_range(99) >= 37);
      end
   end

   task automatic send_item(input logic signed [15:0] s, input logic restart);
      if (!steady) begin
         while ($urandom_range(99) < 37) begin
            push <= 1'b0;
            @(posedge clock);
         end
      end
      push <= 1'b1;
      req_sample_in <= s;
      req_restart <= restart;
      do @(posedge clock); while (full);
   endtask

   // let every expected result arrive, then wait out the tail
   task automatic settle(input int tail);
      push <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
      repeat (tail) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] value);
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      board.write_reg(idx, value);
      @(posedge clock);
   endtask

   task automatic program_regs(input logic [CSR_W-1:0] rec, input logic [CSR_W-1:0] ramp,
                               input logic [CSR_W-1:0] step, input logic [CSR_W-1:0] chunk);
      settle(4);
      csr_write(REG_RECORD_FRAMES, rec);
      csr_write(REG_RAMP_FRAMES, ramp);
      csr_write(REG_RAMP_STEP, step);
      csr_write(REG_CHUNK_SAMPLES, chunk);
      csr_wen <= 1'b0;
   endtask

   function automatic logic signed [15:0] random_sample();
      logic [31:0] r = $urandom;
      if ($urandom_range(7) == 0) begin
         case ($urandom_range(4))
            0: return S_MAX;
            1: return S_MIN;
            2: return 16'sd0;
            3: return -16'sd1;
            default: return 16'sd1;
         endcase
      end
      return r[15:0];
   endfunction

   // mostly whole recordings with random content, some cut short or restarted early
   task automatic random_phase(input int target, input bit pressure);
      logic [CSR_W-1:0] rec, ramp, step, chunk;
      int sent, burst, i;
      bit broken;
      rec = ($urandom_range(9) == 0) ? 21'd0 : 21'($urandom_range(1, 24));
      ramp = CSR_W'($urandom_range(0, int'(rec) + 4));
      case ($urandom_range(5))
         0: step = '0;
         1: step = CSR_W'(GAIN_ONE);
         2, 3: step = CSR_W'($urandom_range(1, 4000));
         default: step = CSR_W'($urandom_range(0, 65536));
      endcase
      chunk = ($urandom_range(4) == 0) ? 21'($urandom_range(0, 1048576))
                                       : 21'($urandom_range(0, 8));
      program_regs(rec, ramp, step, chunk);
      sent = 0;
      while (sent < target) begin
         broken = ($urandom_range(4) == 0);
         burst = broken ? int'($urandom_range(1, int'(rec) + 1))
                        : int'(rec) + int'($urandom_range(1, 2));
         for (i = 0; i < burst && sent < target; i++) begin
            send_item(random_sample(), (i == 0) || (broken && $urandom_range(19) == 0));
            sent++;
            if (pressure && sent == target / 2) settle(0);
         end
      end
   endtask

   initial begin
      int p;
      board = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // short recording: fade-in saturating, pass-through middle, fade-out, last-frame chunk
      program_regs(21'd6, 21'd2, 21'd40000, 21'd2);
      send_item(S_MAX, 1'b1);
      send_item(S_MIN, 1'b0);
      send_item(S_MAX, 1'b0);
      send_item(-16'sd1, 1'b0);
      send_item(S_MIN, 1'b0);
      send_item(S_MAX, 1'b0);
      send_item(16'sd100, 1'b0);
      send_item(S_MIN, 1'b1);

      // zero-length recording: start then drop
      program_regs(21'd0, 21'd0, 21'd0, 21'd0);
      send_item(16'sd1234, 1'b1);
      send_item(-16'sd1234, 1'b0);

      // ramp longer than the recording; step above 17 bits gets masked to unity
      program_regs(21'd3, 21'd5, 21'h1f0000, 21'd0);
      send_item(S_MAX, 1'b1);
      send_item(S_MIN, 1'b0);
      send_item(-16'sd3, 1'b0);
      send_item(S_MAX, 1'b0);

      // single frame, no ramps, chunk limit at 1048576
      program_regs(21'd1, 21'd0, 21'd0, 21'd1048576);
      send_item(S_MIN, 1'b1);
      send_item(S_MAX, 1'b0);

      // recording, ramp and chunk limit at 1048576, ramp step of one
      program_regs(21'd1048576, 21'd1048576, 21'd1, 21'd1048576);
      send_item(S_MAX, 1'b1);
      send_item(S_MIN, 1'b0);
      send_item(S_MAX, 1'b0);
      send_item(16'sd0, 1'b0);

      for (p = 0; p < 8; p++) begin
         steady = (p == 4);
         random_phase(52, p == 2);
      end
      steady = 1'b0;

      settle(10);
      $display("run covered %0d items: %0d sample writes, %0d chunk summaries, %0d drops",
               board.items, board.writes, board.chunks, board.drops);
      $display("settings spanned empty, single-frame and maximum-length recordings");
      if (board.errors == 0 && board.pending() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

>>> filelist.f
+incdir+sv
sv/rfps_pkg.sv
sv/rfps_queue.sv
sv/rfps_front.sv
sv/rfps_back.sv
sv/recorder_fade_and_peak_summary.sv
tb/tb_recorder_fade_and_peak_summary.sv
